### src/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RH_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define RH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/rh_pkg.sv
// ----------------------------------------------------------------------------
// rh_pkg
// Constants, types and helpers for the rapidhash v1 byte stream engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rh_pkg;

  localparam int LEN_W       = 32;
  localparam int HIST_DEPTH  = 64;
  localparam int HIST_AW     = $clog2(HIST_DEPTH);
  localparam int BLOCK_BYTES = 48;

  localparam logic [63:0] SECRET_ZERO = 64'h2d358dccaa6c78a5;
  localparam logic [63:0] SECRET_ONE  = 64'h8bb84b93962eacc9;
  localparam logic [63:0] SECRET_TWO  = 64'h4b33a62ed433d4a3;
  localparam logic [63:0] SEED_INIT   = 64'hbdd89aa982704029;

  // multiply with xor fold, used on constants only
  function automatic logic [63:0] fold_mul_c(input logic [63:0] x, input logic [63:0] y);
    logic [127:0] p;
    p = {64'b0, x} * {64'b0, y};
    return p[63:0] ^ p[127:64];
  endfunction

  // seed before the length is folded in
  localparam logic [63:0] SEED_BASE =
    SEED_INIT ^ fold_mul_c(SEED_INIT ^ SECRET_ZERO, SECRET_ONE);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_LOAD  = 5'b00100,
    ST_MUL   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    RND_LANE0 = 3'd0,
    RND_LANE1 = 3'd1,
    RND_LANE2 = 3'd2,
    RND_PRE1  = 3'd3,
    RND_PRE2  = 3'd4,
    RND_FINAL = 3'd5,
    RND_FOLD  = 3'd6
  } round_t;

  typedef enum logic [1:0] {
    LC_ZERO  = 2'd0,
    LC_SMALL = 2'd1,
    LC_MID   = 2'd2,
    LC_LONG  = 2'd3
  } len_class_t;

endpackage

`default_nettype wire

### src/rh_ifs.sv
// ----------------------------------------------------------------------------
// rh_ifs
// Valid/ready channels for message bytes in and hash results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rh_in_if;
  import rh_pkg::*;
  logic             valid;
  logic             ready;
  logic [7:0]       data_byte;
  logic [LEN_W-1:0] message_length;
  logic             last;
  modport source (output valid, data_byte, message_length, last, input ready);
  modport sink   (input valid, data_byte, message_length, last, output ready);
endinterface

interface rh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;
  logic        length_mismatch;
  modport source (output valid, hash_value, length_mismatch, input ready);
  modport sink   (input valid, hash_value, length_mismatch, output ready);
endinterface

`default_nettype wire

### src/rh_mul.sv
// ----------------------------------------------------------------------------
// rh_mul
// Shared 64x64 to 128 multiplier: one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rh_mul (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] x,
  input  wire logic [63:0] y,
  output logic             done,
  output logic [63:0]      lo,
  output logic [63:0]      hi
);
  import rh_pkg::*;

  logic [63:0]  x_r, y_r;
  logic [63:0]  pp_r;
  logic [1:0]   ppi_r;
  logic [127:0] acc_r;
  logic [2:0]   ph_r;
  logic         busy_r, done_r;
  logic [31:0]  xa, yb;
  logic [127:0] addend;

  // operand halves for this phase
  always_comb begin
    unique case (ph_r[1:0])
      2'd0: begin xa = x_r[31:0];  yb = y_r[31:0];  end
      2'd1: begin xa = x_r[31:0];  yb = y_r[63:32]; end
      2'd2: begin xa = x_r[63:32]; yb = y_r[31:0];  end
      default: begin xa = x_r[63:32]; yb = y_r[63:32]; end
    endcase
  end

  // place the previous partial product
  always_comb begin
    case (ppi_r)
      2'd0:    addend = {64'b0, pp_r};
      2'd3:    addend = {pp_r, 64'b0};
      default: addend = {32'b0, pp_r, 32'b0};
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        ph_r   <= '0;
      end else if (busy_r) begin
        if (ph_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          ph_r <= ph_r + 3'd1;
        end
      end
    end
  end

  // datapath: product one phase, accumulate the next
  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x;
      y_r   <= y;
      acc_r <= '0;
    end else if (busy_r) begin
      if (ph_r != 3'd4) begin
        pp_r  <= xa * yb;
        ppi_r <= ph_r[1:0];
      end
      if (ph_r != 3'd0) begin
        acc_r <= acc_r + addend;
      end
    end
  end

  assign done = done_r;
  assign lo   = acc_r[63:0];
  assign hi   = acc_r[127:64];

  `RH_ASSERT_IMPLY(a_mul_no_restart, clk, rst_n, start, !busy_r, "multiplier restarted while busy")

endmodule

`default_nettype wire

### src/rh_hist.sv
// ----------------------------------------------------------------------------
// rh_hist
// 64-byte message history, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rh_hist (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [rh_pkg::HIST_AW-1:0] waddr,
  input  wire logic [7:0]                wdata,
  input  wire logic [rh_pkg::HIST_AW-1:0] raddr,
  output logic [7:0]                     rdata
);
  import rh_pkg::*;

  logic [7:0] mem [HIST_DEPTH];
  logic [7:0] rdata_r;

  // byte store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### src/rapidhash_v1_byte_stream.sv
// ----------------------------------------------------------------------------
// rapidhash_v1_byte_stream
// 64-bit rapidhash v1 over a byte stream, one shared multiplier under a
// small sequencer, with length mismatch detection.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                | handshake
//  in_ch    | in  | data_byte, message_length, last        | valid/ready
//  out_ch   | out | hash_value, length_mismatch            | valid/ready
//
//  A byte that does not close a 48-byte block is taken in the idle step; a
//  closing byte of a message longer than 48 bytes runs three rounds, each of
//  two history gathers and a pass of the shared multiplier.
//  The last item adds a check step, the PRE rounds the length needs, a FINAL
//  round and a fold multiply; a mismatch goes from check straight to emit.
//  Reset is synchronous; a waiting result holds the engine in its emit step.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rapidhash_v1_byte_stream (
  input  wire logic clk,
  input  wire logic rst_n,
  rh_in_if.sink     in_ch,
  rh_out_if.source  out_ch
);
  import rh_pkg::*;

  state_t             state_r;
  round_t             rnd_r;
  len_class_t         lcls_r;
  logic               phase_r;
  logic [LEN_W-1:0]   decl_r, rcv_r;
  logic               over_r;
  logic [5:0]         mod_r;
  logic [63:0]        lane0_r, lane1_r, lane2_r;
  logic               pend_fin_r, fold_go_r, rest32_r;
  logic [HIST_AW-1:0] mixbase_r, fbase_r;
  logic               side_r;
  logic [3:0]         cnt_r;
  logic               zero_d_r;
  logic [63:0]        sh_r, opa_r, mx_r, my_r;
  logic               mul_go_r;
  logic [63:0]        res_hash_r, out_hash_r;
  logic               res_mis_r, out_mis_r, out_valid_r;

  logic               in_acc, first, take, over_nxt, mix_go, fold_go;
  logic [LEN_W-1:0]   len_eff, rcv_base, rcv_nxt;
  logic               over_base;
  logic [5:0]         mod_base, mod_nxt;
  logic [HIST_AW-1:0] rd_addr, len6, delta;
  logic               rd_zero;
  logic [2:0]         j;
  logic [7:0]         rd_data;
  logic [63:0]        sh_nxt, key_a, key_b, lane_sel;
  logic               mul_done;
  logic [63:0]        mul_lo, mul_hi, fold;
  len_class_t         lcls_c;
  logic [5:0]         rest_c;

  // byte intake and block schedule
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign first     = !phase_r;
  assign len_eff   = first ? in_ch.message_length : decl_r;
  assign rcv_base  = first ? '0 : rcv_r;
  assign over_base = first ? 1'b0 : over_r;
  assign mod_base  = first ? '0 : mod_r;
  assign take      = !(first && in_ch.message_length == '0 && in_ch.last);

  always_comb begin
    rcv_nxt  = rcv_base;
    over_nxt = over_base;
    mod_nxt  = mod_base;
    if (take) begin
      if (rcv_base == '1) begin
        over_nxt = 1'b1;
      end else begin
        rcv_nxt = rcv_base + 1'b1;
        mod_nxt = (mod_base == 6'(BLOCK_BYTES - 1)) ? 6'd0 : mod_base + 6'd1;
      end
    end
  end

  assign mix_go  = take && !over_nxt && (len_eff > LEN_W'(BLOCK_BYTES)) &&
                   (mod_nxt == 6'd0) && (rcv_nxt <= len_eff);
  assign fold_go = (len_eff - rcv_nxt) < LEN_W'(BLOCK_BYTES);

  // finishing parameters from the declared length
  assign lcls_c = (decl_r == '0) ? LC_ZERO :
                  (decl_r < LEN_W'(4)) ? LC_SMALL :
                  (decl_r <= LEN_W'(16)) ? LC_MID : LC_LONG;
  assign rest_c = (decl_r <= LEN_W'(BLOCK_BYTES)) ? decl_r[5:0] : mod_r;

  // history gather addresses, byte j of the current operand
  assign j     = cnt_r[2:0];
  assign len6  = decl_r[HIST_AW-1:0];
  assign delta = (len6 >= 6'd8) ? 6'd4 : 6'd0;

  always_comb begin
    rd_addr = '0;
    rd_zero = 1'b0;
    unique case (rnd_r) inside
      RND_LANE0, RND_LANE1, RND_LANE2:
        rd_addr = mixbase_r + {rnd_r[1:0], 4'b0} + {2'b0, side_r, j};
      RND_PRE1: rd_addr = fbase_r + {2'b0, side_r, j};
      RND_PRE2: rd_addr = fbase_r + 6'd16 + {2'b0, side_r, j};
      RND_FINAL: begin
        unique case (lcls_r)
          LC_ZERO: rd_zero = 1'b1;
          LC_SMALL: begin
            if (side_r) begin
              rd_zero = 1'b1;
            end else begin
              case (j)
                3'd0:    rd_addr = len6 - 6'd1;
                3'd4:    rd_addr = {5'b0, len6[1]};
                3'd7:    rd_addr = '0;
                default: rd_zero = 1'b1;
              endcase
            end
          end
          LC_MID: begin
            if (!j[2]) begin
              rd_addr = side_r ? len6 - 6'd4 - delta + {3'b0, j}
                               : len6 - 6'd4 + {3'b0, j};
            end else begin
              rd_addr = side_r ? delta + {4'b0, j[1:0]} : {4'b0, j[1:0]};
            end
          end
          default: rd_addr = len6 - 6'd16 + {2'b0, side_r, j};
        endcase
      end
      default: rd_zero = 1'b1;
    endcase
  end

  rh_hist u_hist (
    .clk   (clk),
    .we    (in_acc && take),
    .waddr (rcv_base[HIST_AW-1:0]),
    .wdata (in_ch.data_byte),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign sh_nxt = {zero_d_r ? 8'h00 : rd_data, sh_r[63:8]};

  // operand keys per round
  always_comb begin
    case (rnd_r[1:0])
      2'd0:    lane_sel = lane0_r;
      2'd1:    lane_sel = lane1_r;
      default: lane_sel = lane2_r;
    endcase
  end

  always_comb begin
    key_a = '0;
    key_b = '0;
    unique case (rnd_r) inside
      RND_LANE0: begin key_a = SECRET_ZERO; key_b = lane_sel; end
      RND_LANE1: begin key_a = SECRET_ONE;  key_b = lane_sel; end
      RND_LANE2: begin key_a = SECRET_TWO;  key_b = lane_sel; end
      RND_PRE1:  begin key_a = SECRET_TWO;  key_b = lane0_r ^ SECRET_ONE; end
      RND_PRE2:  begin key_a = SECRET_TWO;  key_b = lane0_r; end
      RND_FINAL: begin key_a = SECRET_ONE;  key_b = lane0_r; end
      default: ;
    endcase
  end

  rh_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go_r),
    .x     (mx_r),
    .y     (my_r),
    .done  (mul_done),
    .lo    (mul_lo),
    .hi    (mul_hi)
  );

  assign fold = mul_lo ^ mul_hi;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= RND_LANE0;
      phase_r     <= 1'b0;
      decl_r      <= '0;
      rcv_r       <= '0;
      over_r      <= 1'b0;
      mod_r       <= '0;
      lane0_r     <= '0;
      lane1_r     <= '0;
      lane2_r     <= '0;
      pend_fin_r  <= 1'b0;
      side_r      <= 1'b0;
      cnt_r       <= '0;
      mul_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mul_go_r <= 1'b0;
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (first) begin
              decl_r  <= len_eff;
              lane0_r <= SEED_BASE ^ {32'b0, len_eff};
              lane1_r <= SEED_BASE ^ {32'b0, len_eff};
              lane2_r <= SEED_BASE ^ {32'b0, len_eff};
            end
            phase_r    <= !in_ch.last;
            rcv_r      <= rcv_nxt;
            over_r     <= over_nxt;
            mod_r      <= mod_nxt;
            pend_fin_r <= in_ch.last;
            fold_go_r  <= fold_go;
            mixbase_r  <= rcv_nxt[HIST_AW-1:0] + 6'd16;
            if (mix_go) begin
              rnd_r   <= RND_LANE0;
              side_r  <= 1'b0;
              cnt_r   <= '0;
              state_r <= ST_LOAD;
            end else if (in_ch.last) begin
              state_r <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if (over_r || rcv_r != decl_r) begin
            res_hash_r <= '0;
            res_mis_r  <= 1'b1;
            state_r    <= ST_EMIT;
          end else begin
            lcls_r   <= lcls_c;
            fbase_r  <= len6 - rest_c;
            rest32_r <= rest_c > 6'd32;
            rnd_r    <= (lcls_c == LC_LONG && rest_c > 6'd16) ? RND_PRE1 : RND_FINAL;
            side_r   <= 1'b0;
            cnt_r    <= '0;
            state_r  <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          zero_d_r <= rd_zero;
          if (cnt_r != 4'd0) begin
            sh_r <= sh_nxt;
          end
          if (cnt_r == 4'd8) begin
            cnt_r <= '0;
            if (!side_r) begin
              opa_r  <= sh_nxt;
              side_r <= 1'b1;
            end else begin
              mx_r     <= opa_r ^ key_a;
              my_r     <= sh_nxt ^ key_b;
              side_r   <= 1'b0;
              mul_go_r <= 1'b1;
              state_r  <= ST_MUL;
            end
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            unique case (rnd_r)
              RND_LANE0: begin
                lane0_r <= fold;
                rnd_r   <= RND_LANE1;
                state_r <= ST_LOAD;
              end
              RND_LANE1: begin
                lane1_r <= fold;
                rnd_r   <= RND_LANE2;
                state_r <= ST_LOAD;
              end
              RND_LANE2: begin
                lane2_r <= fold;
                if (fold_go_r) begin
                  lane0_r <= lane0_r ^ lane1_r ^ fold;
                end
                state_r <= pend_fin_r ? ST_CHECK : ST_IDLE;
              end
              RND_PRE1: begin
                lane0_r <= fold;
                rnd_r   <= rest32_r ? RND_PRE2 : RND_FINAL;
                state_r <= ST_LOAD;
              end
              RND_PRE2: begin
                lane0_r <= fold;
                rnd_r   <= RND_FINAL;
                state_r <= ST_LOAD;
              end
              RND_FINAL: begin
                mx_r     <= mul_lo ^ SECRET_ZERO ^ {32'b0, decl_r};
                my_r     <= mul_hi ^ SECRET_ONE;
                mul_go_r <= 1'b1;
                rnd_r    <= RND_FOLD;
              end
              default: begin
                res_hash_r <= fold;
                res_mis_r  <= 1'b0;
                state_r    <= ST_EMIT;
              end
            endcase
          end
        end
        ST_EMIT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_hash_r  <= res_hash_r;
            out_mis_r   <= res_mis_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ch.ready            = (state_r == ST_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.hash_value      = out_hash_r;
  assign out_ch.length_mismatch = out_mis_r;

  `RH_ASSERT_IMPLY(a_mis_hash_zero, clk, rst_n, out_ch.valid && out_ch.length_mismatch, out_ch.hash_value == 64'd0, "mismatch result carries a nonzero hash")
  `RH_ASSERT_NEXT(a_last_busy, clk, rst_n, in_acc && in_ch.last, !in_ch.ready, "ready right after a last item")
  `RH_ASSERT_IMPLY(a_done_in_mul, clk, rst_n, mul_done, state_r == ST_MUL, "multiplier finished outside the multiply step")
  `RH_ASSERT_IMPLY(a_gather_range, clk, rst_n, state_r == ST_LOAD, cnt_r <= 4'd8, "gather counter out of range")

endmodule

`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rapidhash v1 byte stream engine: a short
// table of directed messages, then random messages with random stalls on
// both channels, results checked against a cycle-free model or typed rows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  import rh_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int RANDOM_ITEMS   = 1800;

  typedef enum logic {AWAIT_FIRST, IN_MESSAGE} msg_phase_t;

  typedef struct packed {
    logic [63:0] hash_value;
    logic        length_mismatch;
  } hash_result_t;

  typedef struct {
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] message_length;
    logic             last;
    bit               typed;
    logic [63:0]      hash_value;
    logic             length_mismatch;
  } stim_row_t;

  logic clk;
  logic rst_n;

  rh_in_if  in_ch ();
  rh_out_if out_ch ();

  rapidhash_v1_byte_stream u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // hash model state
  logic [7:0]       msg_bytes [64];
  logic [63:0]      lane_acc [3];
  logic [LEN_W-1:0] byte_count;
  logic [LEN_W-1:0] msg_len;
  msg_phase_t       phase;
  bit               count_sat;

  hash_result_t expected_hashes [$];
  int  error_count;
  int  idle_cycles;
  bit  row_typed;
  hash_result_t row_result;
  stim_row_t dir_rows [$];

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic logic [63:0] mul_fold(input logic [63:0] x, input logic [63:0] y);
    logic [127:0] p;
    p = {64'b0, x} * {64'b0, y};
    return p[63:0] ^ p[127:64];
  endfunction

  function automatic logic [63:0] read_le(input logic [63:0] pos, input int nbytes);
    logic [63:0] v;
    v = '0;
    for (int j = 0; j < nbytes; j++) begin
      v |= 64'(msg_bytes[(pos + j) % 64]) << (8 * j);
    end
    return v;
  endfunction

  function automatic logic [63:0] closing_hash();
    logic [63:0]  len;
    logic [63:0]  s0, a, b, base, rest, delta;
    logic [127:0] p;
    len = 64'(msg_len);
    s0  = lane_acc[0];
    if (len == 0) begin
      a = '0;
      b = '0;
    end else if (len < 4) begin
      a = (64'(msg_bytes[0]) << 56) | (64'(msg_bytes[(len >> 1) % 64]) << 32)
        | 64'(msg_bytes[(len - 1) % 64]);
      b = '0;
    end else if (len <= 16) begin
      delta = (len >= 8) ? 64'd4 : 64'd0;
      a = (read_le(0, 4) << 32) | read_le(len - 4, 4);
      b = (read_le(delta, 4) << 32) | read_le(len - 4 - delta, 4);
    end else begin
      base = (len > 48) ? (len / 48) * 48 : 64'd0;
      rest = len - base;
      if (rest > 16) begin
        s0 ^= SECRET_ONE;
        s0 = mul_fold(read_le(base, 8) ^ SECRET_TWO, read_le(base + 8, 8) ^ s0);
        if (rest > 32) begin
          s0 = mul_fold(read_le(base + 16, 8) ^ SECRET_TWO, read_le(base + 24, 8) ^ s0);
        end
      end
      a = read_le(len - 16, 8);
      b = read_le(len - 8, 8);
    end
    a ^= SECRET_ONE;
    b ^= s0;
    p = {64'b0, a} * {64'b0, b};
    return mul_fold(p[63:0] ^ SECRET_ZERO ^ len, p[127:64] ^ SECRET_ONE);
  endfunction

  // advance the model by one item, returns 1 when a hash comes out
  function automatic bit hash_byte(input logic [7:0] data, input logic [LEN_W-1:0] len_in,
                                   input logic last, output hash_result_t res);
    logic [63:0] s;
    logic [63:0] base;
    bit take;
    bit mis;
    take = 1;
    res  = '0;
    if (phase == AWAIT_FIRST) begin
      msg_len    = len_in;
      byte_count = '0;
      count_sat  = 0;
      s = SEED_INIT;
      s ^= mul_fold(s ^ SECRET_ZERO, SECRET_ONE) ^ 64'(msg_len);
      lane_acc[0] = s;
      lane_acc[1] = s;
      lane_acc[2] = s;
      phase = IN_MESSAGE;
      if (msg_len == 0 && last) take = 0;
    end
    if (take) begin
      msg_bytes[byte_count % 64] = data;
      if (byte_count == '1) count_sat = 1;
      else byte_count++;
      if (!count_sat && msg_len > 48 && byte_count % 48 == 0 && byte_count <= msg_len) begin
        base = 64'(byte_count) - 48;
        lane_acc[0] = mul_fold(read_le(base, 8) ^ SECRET_ZERO, read_le(base + 8, 8) ^ lane_acc[0]);
        lane_acc[1] = mul_fold(read_le(base + 16, 8) ^ SECRET_ONE,
                               read_le(base + 24, 8) ^ lane_acc[1]);
        lane_acc[2] = mul_fold(read_le(base + 32, 8) ^ SECRET_TWO,
                               read_le(base + 40, 8) ^ lane_acc[2]);
        if (msg_len - byte_count < 48) lane_acc[0] ^= lane_acc[1] ^ lane_acc[2];
      end
    end
    if (!last) return 0;
    phase = AWAIT_FIRST;
    mis = count_sat || byte_count != msg_len;
    res.hash_value      = mis ? 64'd0 : closing_hash();
    res.length_mismatch = mis;
    return 1;
  endfunction

  // input monitor: runs the model on each accepted item
  always @(posedge clk) begin
    hash_result_t res;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (hash_byte(in_ch.data_byte, in_ch.message_length, in_ch.last, res)) begin
        expected_hashes.push_back(row_typed ? row_result : res);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    hash_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_hashes.size() == 0) begin
        $display("%0t: unexpected result hash=%h mismatch=%b", $time,
                 out_ch.hash_value, out_ch.length_mismatch);
        error_count++;
      end else begin
        exp_r = expected_hashes.pop_front();
        if (out_ch.hash_value !== exp_r.hash_value) begin
          $display("%0t: hash_value expected %h actual %h", $time,
                   exp_r.hash_value, out_ch.hash_value);
          error_count++;
        end
        if (out_ch.length_mismatch !== exp_r.length_mismatch) begin
          $display("%0t: length_mismatch expected %b actual %b", $time,
                   exp_r.length_mismatch, out_ch.length_mismatch);
          error_count++;
        end
      end
    end
  end

  // result side stalls: mostly short, a few long, and quiet stretches
  int stall_left;
  always @(posedge clk) begin
    int r;
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      r = $urandom_range(0, 99);
      if (r < 20) stall_left <= $urandom_range(1, 3);
      else if (r < 23) stall_left <= $urandom_range(15, 40);
    end
  end

  // watchdog on cycles without any accepted item or result
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** rapidhash_v1_byte_stream: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // drive one item and wait until it is taken
  task automatic drive_item(input stim_row_t row);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    row_typed  <= row.typed;
    row_result <= '{hash_value: row.hash_value, length_mismatch: row.length_mismatch};
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= row.data_byte;
    in_ch.message_length <= row.message_length;
    in_ch.last           <= row.last;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  function automatic stim_row_t mk_row(input logic [7:0] d, input logic [LEN_W-1:0] l,
                                       input logic lst, input bit t = 0,
                                       input logic [63:0] h = '0, input logic m = 1'b0);
    stim_row_t row;
    row.data_byte = d;
    row.message_length = l;
    row.last = lst;
    row.typed = t;
    row.hash_value = h;
    row.length_mismatch = m;
    return row;
  endfunction

  // one random message, well formed most of the time
  task automatic send_message(ref int sent);
    int len, count, r;
    logic [LEN_W-1:0] decl;
    r = $urandom_range(0, 99);
    if (r < 45) len = $urandom_range(0, 16);
    else if (r < 80) len = $urandom_range(17, 64);
    else len = $urandom_range(65, 200);
    decl  = LEN_W'(len);
    count = len;
    r = $urandom_range(0, 99);
    if (r < 6) count = len + $urandom_range(1, 50);
    else if (r < 11 && len > 0) count = $urandom_range(0, len - 1);
    else if (r < 15) begin
      decl  = $urandom;
      count = $urandom_range(0, 20);
    end
    if (count == 0 && decl != 0) count = 1;
    if (count == 0) begin
      drive_item(mk_row(8'($urandom), decl, 1'b1));
      sent++;
    end else begin
      for (int i = 0; i < count; i++) begin
        drive_item(mk_row(8'($urandom), (i == 0) ? decl : LEN_W'($urandom), i == count - 1));
        sent++;
      end
    end
  endtask

  initial begin
    int sent;
    error_count = 0;
    idle_cycles = 0;
    stall_left  = 0;
    phase       = AWAIT_FIRST;
    byte_count  = '0;
    msg_len     = '0;
    count_sat   = 0;
    row_typed   = 0;
    row_result  = '0;
    foreach (lane_acc[i]) lane_acc[i] = '0;
    foreach (msg_bytes[i]) msg_bytes[i] = '0;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.data_byte      = '0;
    in_ch.message_length = '0;
    in_ch.last           = 1'b0;
    out_ch.ready         = 1'b0;

    // directed messages
    dir_rows.push_back(mk_row(8'ha5, 0, 1'b1));
    dir_rows.push_back(mk_row(8'hff, 1, 1'b1));
    dir_rows.push_back(mk_row(8'h00, 3, 1'b0));
    dir_rows.push_back(mk_row(8'h80, 0, 1'b0));
    dir_rows.push_back(mk_row(8'hff, 0, 1'b1));
    dir_rows.push_back(mk_row(8'h12, 2, 1'b1, 1'b1, 64'd0, 1'b1));
    dir_rows.push_back(mk_row(8'hff, 32'hffffffff, 1'b1, 1'b1, 64'd0, 1'b1));
    dir_rows.push_back(mk_row(8'h00, 0, 1'b0));
    dir_rows.push_back(mk_row(8'hff, 0, 1'b1, 1'b1, 64'd0, 1'b1));
    dir_rows.push_back(mk_row(8'h01, 4, 1'b0));
    dir_rows.push_back(mk_row(8'h7f, 32'hffffffff, 1'b0));
    dir_rows.push_back(mk_row(8'hfe, 32'h0, 1'b0));
    dir_rows.push_back(mk_row(8'h55, 32'haaaaaaaa, 1'b1));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) drive_item(dir_rows[i]);

    // random messages
    sent = 0;
    while (sent < RANDOM_ITEMS) send_message(sent);
    in_ch.valid <= 1'b0;

    wait (expected_hashes.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("** rapidhash_v1_byte_stream: PASSED **");
    end else begin
      $display("** rapidhash_v1_byte_stream: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
+incdir+src
src/rh_pkg.sv
src/rh_ifs.sv
src/rh_mul.sv
src/rh_hist.sv
src/rapidhash_v1_byte_stream.sv
test/tb_top.sv
